// ----- rtl/bwm_pkg.sv -----
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared types and constants for the busy/idle window monitor.
// ----------------------------------------------------------------------------
package bwm_pkg;

	localparam int TW              = 63;   // time and total width
	localparam int BW              = 16;   // bucket count width
	localparam int US_W            = 20;   // width of the microseconds-per-second constant
	localparam int RING_DEPTH_DEF  = 64;

	localparam logic [BW-1:0]   BS_RESET = 16'd1000;
	localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

	localparam int IN_DW   = 80;           // now_us + window_s, byte padded
	localparam int OUT_DW  = 384;          // six 63-bit fields + flag, byte padded
	localparam int OUT_PAD = OUT_DW - (6 * TW + 1);

	typedef enum logic [1:0] {
		ACT_WAIT_BEGIN,
		ACT_WAIT_END,
		ACT_RESET,
		ACT_QUERY
	} action_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_FCHK,
		ST_FRD,
		ST_FWALK,
		ST_LDIV,
		ST_LSWEEP,
		ST_QNEED,
		ST_QMUL,
		ST_QCMP,
		ST_QDIVK,
		ST_QKMUL,
		ST_QKADD,
		ST_QWALK,
		ST_QFIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		action_t         action;
		logic [TW-1:0]   now_us;
		logic [BW-1:0]   window_s;
	} item_t;

	typedef struct packed {
		logic [TW-1:0]   idle_total_us;
		logic [TW-1:0]   active_total_us;
		logic            is_waiting;
		logic [TW-1:0]   window_idle_us;
		logic [TW-1:0]   window_active_us;
		logic [TW-1:0]   window_us;
		logic [TW-1:0]   start_us;
	} res_t;

	typedef struct packed {
		logic            start;
		logic [TW-1:0]   dividend;
		logic [BW-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [TW-1:0]   quot;
		logic [BW-1:0]   rem;
	} div_rsp_t;

endpackage

// ----- rtl/bwm_div.sv -----
// ----------------------------------------------------------------------------
// bwm_div
// Restoring radix-2 divider, 63-bit dividend by 16-bit divisor, one
// quotient bit per cycle. done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
module bwm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bwm_pkg::div_req_t  req,
	output bwm_pkg::div_rsp_t  rsp
);
	import bwm_pkg::*;

	localparam int CW = $clog2(TW + 1);

	logic [TW-1:0] quo_q;
	logic [BW-1:0] rem_q;
	logic [BW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [BW:0]   trial;
	logic [BW:0]   diff;
	logic          take;

	// partial remainder stays below the divisor, so trial fits BW+1 bits
	assign trial = {rem_q, quo_q[TW-1]};
	assign take  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TW-2:0], take};
			rem_q <= take ? diff[BW-1:0] : trial[BW-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- rtl/bwm_core.sv -----
// ----------------------------------------------------------------------------
// bwm_core
// Sequencer around the bucket memory: clearing sweeps, bucket-by-bucket
// fill, wholesale fill and the windowed query walk.
// ----------------------------------------------------------------------------
module bwm_core #(
	parameter int RING_DEPTH = bwm_pkg::RING_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bwm_pkg::BW-1:0]    bs,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bwm_pkg::item_t            item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bwm_pkg::res_t             res
);
	import bwm_pkg::*;

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int NBW = BW + AW;          // holds RING_DEPTH * bucket size
	localparam int MW  = BW + US_W;
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

	state_t state_q, state_d;

	// bucket memory: {idle, active}
	logic [2*BW-1:0] mem_q [RING_DEPTH];
	logic [2*BW-1:0] rd_data_q;
	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [2*BW-1:0] wr_data;

	div_req_t dreq;
	div_rsp_t drsp;

	logic            flag_q;
	logic [TW-1:0]   begin_q, finish_q, start_q;
	logic [TW-1:0]   idle_sum_q, act_tot_q;
	logic [AW-1:0]   wp_q, idx_q;

	logic            kind_q;
	logic [TW-1:0]   e_q, ival_q;
	logic [AW-1:0]   need_q, k_q, left_q;
	logic [NBW-1:0]  prod_q, kb_q, rem_q;
	logic [BW-1:0]   sp_q, cur_i_q, cur_a_q, mod_q;
	logic [TW-1:0]   widle_q, wact_q, wlen_q;
	logic            rdp_q, stop_q;
	res_t            res_q;

	logic            acc;
	logic [TW-1:0]   ref_t, e_in, ival_in;
	logic [MW-1:0]   ival_mul;
	logic [NBW-1:0]  nbs;
	logic [BW-1:0]   rd_i, rd_a, sp_rd;
	logic [BW:0]     used_rd;
	logic            fw_done;
	logic [BW-1:0]   fw_add, fw_i, fw_a;
	logic [AW-1:0]   wp_inc, wp_dec, idx_inc, idx_dec;
	logic            walk_issue, walk_hit;
	logic [BW:0]     walk_sum;

	assign acc      = in_valid && in_ready;
	assign in_ready = state_q == ST_IDLE;
	assign nbs      = NBW'(RING_DEPTH) * NBW'(bs);

	always_comb begin
		unique case (item.action)
			ACT_WAIT_BEGIN: ref_t = finish_q;
			ACT_WAIT_END:   ref_t = begin_q;
			ACT_RESET:      ref_t = finish_q;
			ACT_QUERY:      ref_t = flag_q ? begin_q : finish_q;
			default:        ref_t = finish_q;
		endcase
	end

	// time running backwards counts as no time
	assign e_in     = (item.now_us >= ref_t) ? item.now_us - ref_t : '0;
	assign ival_mul = MW'(item.window_s) * MW'(US_PER_S);
	assign ival_in  = (item.window_s != '0) ? TW'(ival_mul) : TW'(nbs);

	assign rd_i    = rd_data_q[2*BW-1:BW];
	assign rd_a    = rd_data_q[BW-1:0];
	assign used_rd = {1'b0, rd_i} + {1'b0, rd_a};
	// an overfull bucket (size lowered since) has no free space
	assign sp_rd   = (used_rd >= {1'b0, bs}) ? '0 : bs - used_rd[BW-1:0];

	assign wp_inc  = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign wp_dec  = (wp_q == '0) ? LAST : wp_q - 1'b1;
	assign idx_inc = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign idx_dec = (idx_q == '0) ? LAST : idx_q - 1'b1;

	assign fw_done = (rem_q == '0) || (rem_q < NBW'(sp_q));
	assign fw_add  = (rem_q < NBW'(sp_q)) ? rem_q[BW-1:0] : sp_q;
	assign fw_i    = kind_q ? cur_i_q + fw_add : cur_i_q;
	assign fw_a    = kind_q ? cur_a_q : cur_a_q + fw_add;

	assign walk_issue = (left_q != '0) && !stop_q;
	assign walk_sum   = {1'b0, rd_i} + {1'b0, rd_a};
	assign walk_hit   = rdp_q && !stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		wr_en         = 1'b0;
		wr_addr       = wp_q;
		wr_data       = {fw_i, fw_a};
		rd_en         = 1'b0;
		rd_addr       = wp_q;
		dreq.start    = 1'b0;
		dreq.dividend = e_q;
		dreq.divisor  = bs;
		res_valid     = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = '0;
				if (idx_q == LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (item.action)
						ACT_WAIT_BEGIN, ACT_WAIT_END: state_d = ST_FCHK;
						ACT_RESET:                    state_d = ST_CLR;
						ACT_QUERY: begin
							dreq.start    = 1'b1;
							dreq.dividend = ival_in;
							state_d       = ST_QNEED;
						end
						default:                      state_d = ST_IDLE;
					endcase
				end
			end
			ST_FCHK: begin
				if (e_q >= TW'(nbs)) begin
					dreq.start = 1'b1;
					state_d    = ST_LDIV;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_FRD;
				end
			end
			ST_FRD: state_d = ST_FWALK;
			ST_FWALK: begin
				wr_en = 1'b1;
				if (fw_done) state_d = ST_IDLE;
			end
			ST_LDIV: begin
				if (drsp.done) state_d = ST_LSWEEP;
			end
			ST_LSWEEP: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				if (idx_q == LAST) begin
					wr_data = kind_q ? {mod_q, {BW{1'b0}}} : {{BW{1'b0}}, mod_q};
					state_d = ST_IDLE;
				end else begin
					wr_data = kind_q ? {bs, {BW{1'b0}}} : {{BW{1'b0}}, bs};
				end
			end
			ST_QNEED: begin
				if (drsp.done) state_d = ST_QMUL;
			end
			ST_QMUL: begin
				rd_en   = 1'b1;
				state_d = ST_QCMP;
			end
			ST_QCMP: begin
				if (e_q >= TW'(prod_q)) begin
					state_d = ST_QFIN;
				end else if (e_q > TW'(sp_rd)) begin
					dreq.start    = 1'b1;
					dreq.dividend = e_q - TW'(sp_rd);
					state_d       = ST_QDIVK;
				end else begin
					state_d = ST_QWALK;
				end
			end
			ST_QDIVK: begin
				if (drsp.done) state_d = ST_QKMUL;
			end
			ST_QKMUL: state_d = ST_QKADD;
			ST_QKADD: state_d = ST_QWALK;
			ST_QWALK: begin
				if (walk_issue) begin
					rd_en   = 1'b1;
					rd_addr = idx_q;
				end
				if (!walk_issue && !rdp_q) state_d = ST_QFIN;
			end
			ST_QFIN: state_d = ST_DONE;
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	bwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// architectural state and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= 1'b0;
			begin_q    <= '0;
			finish_q   <= '0;
			start_q    <= '0;
			idle_sum_q <= '0;
			act_tot_q  <= '0;
			wp_q       <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					wp_q  <= '0;
					idx_q <= idx_inc;
				end
				ST_IDLE: begin
					if (acc) begin
						unique case (item.action)
							ACT_WAIT_BEGIN: begin
								act_tot_q <= act_tot_q + e_in;
								begin_q   <= item.now_us;
								flag_q    <= 1'b1;
							end
							ACT_WAIT_END: begin
								idle_sum_q <= idle_sum_q + e_in;
								finish_q   <= item.now_us;
								flag_q     <= 1'b0;
							end
							ACT_RESET: begin
								start_q    <= item.now_us;
								begin_q    <= item.now_us;
								finish_q   <= item.now_us;
								idle_sum_q <= '0;
								act_tot_q  <= '0;
								idx_q      <= '0;
							end
							ACT_QUERY: ;
							default: ;
						endcase
					end
				end
				ST_FWALK: begin
					if (!fw_done) wp_q <= wp_inc;
				end
				ST_LSWEEP: begin
					idx_q <= idx_inc;
					if (idx_q == LAST) wp_q <= LAST;
				end
				ST_QCMP:  idx_q <= wp_dec;
				ST_QWALK: begin
					if (walk_issue) idx_q <= idx_dec;
				end
				ST_QFIN:  idx_q <= '0;
				default: ;
			endcase
		end
	end

	// working registers of the current beat
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					kind_q  <= item.action == ACT_WAIT_END;
					e_q     <= e_in;
					ival_q  <= ival_in;
					widle_q <= '0;
					wact_q  <= '0;
					wlen_q  <= '0;
				end
			end
			ST_FRD: begin
				cur_i_q <= rd_i;
				cur_a_q <= rd_a;
				sp_q    <= sp_rd;
				rem_q   <= e_q[NBW-1:0];
			end
			ST_FWALK: begin
				if (!fw_done) begin
					rem_q   <= rem_q - NBW'(fw_add);
					cur_i_q <= '0;
					cur_a_q <= '0;
					sp_q    <= bs;
				end
			end
			ST_LDIV: begin
				if (drsp.done) mod_q <= drsp.rem;
			end
			ST_QNEED: begin
				if (drsp.done) begin
					need_q <= (drsp.quot >= TW'(RING_DEPTH - 1)) ? LAST
						: drsp.quot[AW-1:0];
				end
			end
			ST_QMUL: prod_q <= NBW'(need_q) * NBW'(bs);
			ST_QCMP: begin
				if (e_q >= TW'(prod_q)) begin
					wlen_q  <= TW'(prod_q);
					widle_q <= flag_q ? TW'(prod_q) : '0;
					wact_q  <= flag_q ? '0 : TW'(prod_q);
				end
				cur_i_q <= rd_i;
				cur_a_q <= rd_a;
				sp_q    <= sp_rd;
				left_q  <= need_q;
				rdp_q   <= 1'b0;
				stop_q  <= 1'b0;
			end
			ST_QDIVK: begin
				if (drsp.done) k_q <= drsp.quot[AW-1:0];
			end
			ST_QKMUL: kb_q <= NBW'(k_q) * NBW'(bs);
			ST_QKADD: begin
				// the open span fills the current bucket and k whole ones
				widle_q <= widle_q + TW'(cur_i_q)
					+ (flag_q ? TW'(sp_q) + TW'(kb_q) : '0);
				wact_q  <= wact_q + TW'(cur_a_q)
					+ (flag_q ? '0 : TW'(sp_q) + TW'(kb_q));
				wlen_q  <= TW'(kb_q) + TW'(bs);
				left_q  <= need_q - k_q - 1'b1;
			end
			ST_QWALK: begin
				if (walk_issue) left_q <= left_q - 1'b1;
				rdp_q <= walk_issue;
				// an empty bucket ends the history; later reads are dropped
				if (walk_hit) begin
					if (walk_sum == '0) begin
						stop_q <= 1'b1;
					end else begin
						wlen_q  <= wlen_q + TW'(bs);
						widle_q <= widle_q + TW'(rd_i);
						wact_q  <= wact_q + TW'(rd_a);
					end
				end
			end
			ST_QFIN: begin
				res_q.idle_total_us    <= idle_sum_q;
				res_q.active_total_us  <= act_tot_q;
				res_q.is_waiting       <= flag_q;
				res_q.start_us         <= start_q;
				if (wlen_q < ival_q) begin
					res_q.window_idle_us   <= '0;
					res_q.window_active_us <= '0;
					res_q.window_us        <= '0;
				end else begin
					res_q.window_idle_us   <= widle_q;
					res_q.window_active_us <= wact_q;
					res_q.window_us        <= wlen_q;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy)
		else $error("divider started while busy");

	a_clr_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && idx_q == LAST) |=> (wp_q == '0 && state_q == ST_IDLE))
		else $error("clear sweep did not end at position zero");

	a_long_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSWEEP && idx_q == LAST) |=> wp_q == LAST)
		else $error("wholesale fill did not park at last bucket");

	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QWALK && rdp_q) |-> $past(rd_en))
		else $error("walk consumed data without a read");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST)
		else $error("write position out of range");

endmodule

// ----- rtl/busy_idle_window_monitor.sv -----
// ----------------------------------------------------------------------------
// busy_idle_window_monitor
// Busy/idle utilization monitor over a ring of time buckets.
// ----------------------------------------------------------------------------
// Channels: cfg_* writes the bucket size in microseconds (0 acts as 1);
// s_* takes one event beat (tuser = action, tdata = now_us, window_s);
// m_* returns one result beat per query only.
// Work per beat, N = RING_DEPTH, paced by the bucket memory port and
// the bit-serial divider:
//   wait begin/end, span under a full ring: walk over the buckets crossed (at most N)
//   wait begin/end, span of the whole ring: divide, then write sweep
//   reset statistics: clearing sweep
//   query: divide for the bucket count, then finish when the open span alone
//   covers the window; otherwise divide again when the open span crosses
//   buckets, then read each older bucket (at most N-1).
// After reset the memory is cleared before s_tready rises;
// configuration writes are taken at any time.
// A query result waits in the output register; the next beat is accepted
// meanwhile, and only a second query stalls at its end while m_tready is low.
// ----------------------------------------------------------------------------
module busy_idle_window_monitor #(
	parameter int RING_DEPTH = bwm_pkg::RING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bwm_pkg::BW-1:0]        cfg_data,   // bucket_size_us
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bwm_pkg::IN_DW-1:0]     s_tdata,    // now_us, window_s, pad
	input  logic [1:0]                    s_tuser,    // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// idle_total_us, active_total_us, is_waiting, window_idle_us,
	// window_active_us, window_us, start_us, pad
	output logic [bwm_pkg::OUT_DW-1:0]    m_tdata
);
	import bwm_pkg::*;

	logic [BW-1:0]     bs_cfg_q;
	logic [BW-1:0]     bs_eff;
	item_t             item;
	res_t              res;
	logic              res_valid, res_ready;
	logic              m_tvalid_q;
	logic [OUT_DW-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_cfg_q <= BS_RESET;
		end else if (cfg_valid) begin
			bs_cfg_q <= cfg_data;
		end
	end

	assign bs_eff = (bs_cfg_q == '0) ? BW'(1) : bs_cfg_q;

	assign item.action   = action_t'(s_tuser);
	assign item.now_us   = s_tdata[TW-1:0];
	assign item.window_s = s_tdata[TW+BW-1:TW];

	bwm_core #(
		.RING_DEPTH (RING_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.bs        (bs_eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, res.start_us, res.window_us,
				res.window_active_us, res.window_idle_us, res.is_waiting,
				res.active_total_us, res.idle_total_us};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
